@@ src/mscrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mscrc_pkg
// shared types, polynomials and byte fold functions of the crc engine
// ----------------------------------------------------------------------------
package mscrc_pkg;

    localparam int unsigned CRC_W      = 64;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VARIANT_W  = 3;

    typedef enum logic [VARIANT_W-1:0] {
        VAR_J1850 = 3'd0,
        VAR_H2F   = 3'd1,
        VAR_CCITT = 3'd2,
        VAR_ETH   = 3'd3,
        VAR_P4    = 3'd4,
        VAR_ECMA  = 3'd5
    } variant_t;

    localparam logic [7:0]  POLY_J1850 = 8'h1D;
    localparam logic [7:0]  POLY_H2F   = 8'h2F;
    localparam logic [15:0] POLY_CCITT = 16'h1021;
    localparam logic [31:0] RPOLY_ETH  = 32'hEDB8_8320;
    localparam logic [31:0] RPOLY_P4   = 32'hC8DF_352F;
    localparam logic [63:0] RPOLY_ECMA = 64'hC96C_5795_D787_0F42;

    localparam logic [CRC_W-1:0] CRC_ALL_ONES = {CRC_W{1'b1}};

    // unused codes fall back to j1850
    function automatic variant_t decode_variant(input logic [VARIANT_W-1:0] code);
        variant_t v;
        case (code)
            VAR_H2F:   v = VAR_H2F;
            VAR_CCITT: v = VAR_CCITT;
            VAR_ETH:   v = VAR_ETH;
            VAR_P4:    v = VAR_P4;
            VAR_ECMA:  v = VAR_ECMA;
            default:   v = VAR_J1850;
        endcase
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] width_mask(input variant_t v);
        logic [CRC_W-1:0] m;
        case (v)
            VAR_CCITT:       m = {{(CRC_W-16){1'b0}}, 16'hFFFF};
            VAR_ETH, VAR_P4: m = {{(CRC_W-32){1'b0}}, 32'hFFFF_FFFF};
            VAR_ECMA:        m = CRC_ALL_ONES;
            default:         m = {{(CRC_W-8){1'b0}}, 8'hFF};
        endcase
        return m;
    endfunction

    function automatic logic [7:0] fold_msb8(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] fold_msb16(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] fold_lsb32(input logic [31:0] crc,
                                               input logic [7:0]  data,
                                               input logic [31:0] rpoly);
        logic [31:0] c;
        c = crc ^ {24'h0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [63:0] fold_lsb64(input logic [63:0] crc,
                                               input logic [7:0]  data,
                                               input logic [63:0] rpoly);
        logic [63:0] c;
        c = crc ^ {56'h0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ src/mscrc_ifs.sv @@
// ----------------------------------------------------------------------------
// mscrc interfaces
// valid/ready channels for message bytes, crc results and configuration
// ----------------------------------------------------------------------------
interface mscrc_byte_if;
    logic                            valid;
    logic                            ready;
    logic [mscrc_pkg::BYTE_W-1:0]    data_byte;
    logic                            carries_byte;
    logic                            end_of_message;

    modport source (output valid, output data_byte, output carries_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input carries_byte,
                    input end_of_message, output ready);
endinterface

interface mscrc_result_if;
    logic                            valid;
    logic                            ready;
    logic [mscrc_pkg::CRC_W-1:0]     crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

interface mscrc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mscrc_pkg::VARIANT_W-1:0] crc_variant;

    modport source (output valid, output crc_variant, input ready);
    modport sink   (input valid, input crc_variant, output ready);
endinterface

@@ src/multi_standard_crc_engine.sv @@
// ----------------------------------------------------------------------------
// multi_standard_crc_engine
// byte-stream crc engine for six standard crc-8/16/32/64 variants
// ----------------------------------------------------------------------------
// byte_in carries one item per transfer: data_byte, carries_byte and
// end_of_message. an item with carries_byte folds its byte into the running
// crc; an item with end_of_message emits one transfer on crc_out holding the
// final crc (zero-extended to 64 bits) and re-arms the register to all ones.
// cfg selects the variant and is always ready; write it only while idle.
// an item is captured in an input register and folded from there by the
// byte-wide xor network; a closing item's result is loaded into the output
// register, from which the result transfer is made. one item per cycle is
// sustained while no closing item waits for the output register; the bound
// is the combinational fold feeding the running crc.
// when crc_out stalls, the result holds in the output register, one closing
// item may wait in the input register, and byte_in drops ready only when
// that waiting item is a closing one. bytes without end_of_message keep
// flowing while the result waits. reset selects crc-8 j1850 and sets the
// running crc to all ones.
// ----------------------------------------------------------------------------
module multi_standard_crc_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    mscrc_byte_if.sink             byte_in,
    mscrc_result_if.source         crc_out,
    mscrc_cfg_if.sink              cfg
);

    logic [mscrc_pkg::VARIANT_W-1:0] variant_reg;
    mscrc_pkg::variant_t             variant;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [mscrc_pkg::BYTE_W-1:0]    s1_byte_reg;
    logic                            s1_carries_reg;
    logic                            s1_eom_reg;

    logic [mscrc_pkg::CRC_W-1:0]     running_crc_reg;
    logic [mscrc_pkg::CRC_W-1:0]     running_crc_next;

    logic                            o_valid_reg;
    logic                            o_valid_next;
    logic [mscrc_pkg::CRC_W-1:0]     o_crc_reg;

    logic [mscrc_pkg::CRC_W-1:0]     fold_crc;
    logic [mscrc_pkg::CRC_W-1:0]     fold_final;

    logic                            in_xfer;
    logic                            out_free;
    logic                            s1_fire;

    assign variant = mscrc_pkg::decode_variant(variant_reg);

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= '0;
        end
        else if (cfg.valid)
        begin
            variant_reg <= cfg.crc_variant;
        end
    end

    // handshake
    assign out_free      = !o_valid_reg || crc_out.ready;
    assign s1_fire       = s1_valid_reg && (!s1_eom_reg || out_free);
    assign byte_in.ready = !s1_valid_reg || s1_fire;
    assign in_xfer       = byte_in.valid && byte_in.ready;

    // input register
    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg    <= byte_in.data_byte;
            s1_carries_reg <= byte_in.carries_byte;
            s1_eom_reg     <= byte_in.end_of_message;
        end
    end

    // byte fold
    mscrc_fold u_fold (
        .variant      (variant),
        .crc_in       (running_crc_reg),
        .data_byte    (s1_byte_reg),
        .carries_byte (s1_carries_reg),
        .crc_out      (fold_crc),
        .crc_final    (fold_final)
    );

    always_comb
    begin
        running_crc_next = running_crc_reg;
        if (s1_fire)
        begin
            running_crc_next = s1_eom_reg ? mscrc_pkg::CRC_ALL_ONES : fold_crc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= mscrc_pkg::CRC_ALL_ONES;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
        end
    end

    // result register
    always_comb
    begin
        if (s1_fire && s1_eom_reg)
            o_valid_next = 1'b1;
        else if (crc_out.ready)
            o_valid_next = 1'b0;
        else
            o_valid_next = o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_eom_reg)
        begin
            o_crc_reg <= fold_final;
        end
    end

    assign crc_out.valid     = o_valid_reg;
    assign crc_out.crc_value = o_crc_reg;

    // checks
    a_rearm_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_eom_reg) |=> (running_crc_reg == mscrc_pkg::CRC_ALL_ONES))
        else $error("running crc not re-armed after closing item");

    a_idle_item_keeps_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_eom_reg && !s1_carries_reg) |=> $stable(running_crc_reg))
        else $error("idle item changed the running crc");

    a_close_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_eom_reg) |=> o_valid_reg)
        else $error("closing item produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !crc_out.ready) |-> !(s1_fire && s1_eom_reg))
        else $error("pending result overwritten");

endmodule

@@ src/mscrc_fold.sv @@
// ----------------------------------------------------------------------------
// mscrc_fold
// folds one byte into the running crc and forms the final value
// ----------------------------------------------------------------------------
module mscrc_fold (
    input  mscrc_pkg::variant_t                variant,
    input  logic [mscrc_pkg::CRC_W-1:0]        crc_in,
    input  logic [mscrc_pkg::BYTE_W-1:0]       data_byte,
    input  logic                               carries_byte,
    output logic [mscrc_pkg::CRC_W-1:0]        crc_out,
    output logic [mscrc_pkg::CRC_W-1:0]        crc_final
);

    logic [mscrc_pkg::CRC_W-1:0] mask;
    logic [mscrc_pkg::CRC_W-1:0] cur;
    logic [mscrc_pkg::CRC_W-1:0] folded;

    assign mask = mscrc_pkg::width_mask(variant);
    assign cur  = crc_in & mask;

    always_comb
    begin
        case (variant)
            mscrc_pkg::VAR_H2F:
                folded = {56'h0, mscrc_pkg::fold_msb8(cur[7:0], data_byte,
                                                      mscrc_pkg::POLY_H2F)};
            mscrc_pkg::VAR_CCITT:
                folded = {48'h0, mscrc_pkg::fold_msb16(cur[15:0], data_byte,
                                                       mscrc_pkg::POLY_CCITT)};
            mscrc_pkg::VAR_ETH:
                folded = {32'h0, mscrc_pkg::fold_lsb32(cur[31:0], data_byte,
                                                       mscrc_pkg::RPOLY_ETH)};
            mscrc_pkg::VAR_P4:
                folded = {32'h0, mscrc_pkg::fold_lsb32(cur[31:0], data_byte,
                                                       mscrc_pkg::RPOLY_P4)};
            mscrc_pkg::VAR_ECMA:
                folded = mscrc_pkg::fold_lsb64(cur, data_byte, mscrc_pkg::RPOLY_ECMA);
            default:
                folded = {56'h0, mscrc_pkg::fold_msb8(cur[7:0], data_byte,
                                                      mscrc_pkg::POLY_J1850)};
        endcase
    end

    logic [mscrc_pkg::CRC_W-1:0] cur_after;

    assign cur_after = carries_byte ? folded : cur;
    assign crc_out   = (crc_in & ~mask) | cur_after;

    // ccitt-false has no final inversion
    assign crc_final = (variant == mscrc_pkg::VAR_CCITT) ? cur_after : (~cur_after & mask);

endmodule

@@ test/tb_multi_standard_crc_engine.sv @@
// ----------------------------------------------------------------------------
// tb_multi_standard_crc_engine
// self-checking bench for the multi-standard crc engine
// ----------------------------------------------------------------------------
// message bytes are driven through the byte channel in random bursts while the
// result channel stalls on changing patterns, with one long hold-off that
// backs the engine up. a bitwise crc model masks one running register per
// variant and queues the crc of every closed message; each result transfer is
// compared against the oldest queued crc. the variant register is rewritten
// between phases, every code included, sometimes in the middle of a message.
// ----------------------------------------------------------------------------
class crc_tracker;
    logic [mscrc_pkg::CRC_W-1:0]     running_crc;
    logic [mscrc_pkg::VARIANT_W-1:0] variant_code;
    logic [mscrc_pkg::CRC_W-1:0]     pending_crcs[$];
    int                              failures;

    function new();
        running_crc  = mscrc_pkg::CRC_ALL_ONES;
        variant_code = mscrc_pkg::VAR_J1850;
        failures     = 0;
    endfunction

    function void set_variant(logic [mscrc_pkg::VARIANT_W-1:0] code);
        variant_code = code;
    endfunction

    function int pending();
        return pending_crcs.size();
    endfunction

    // bitwise byte update at the width of the selected variant
    function logic [mscrc_pkg::CRC_W-1:0] fold_one_byte(logic [mscrc_pkg::CRC_W-1:0] crc,
                                                        logic [7:0] data,
                                                        mscrc_pkg::variant_t v,
                                                        logic [mscrc_pkg::CRC_W-1:0] mask);
        logic [mscrc_pkg::CRC_W-1:0] c;
        logic [mscrc_pkg::CRC_W-1:0] poly;
        int                          w;
        logic                        carry;
        c = crc;
        case (v)
            mscrc_pkg::VAR_H2F:
            begin
                w    = 8;
                poly = {56'h0, mscrc_pkg::POLY_H2F};
            end
            mscrc_pkg::VAR_CCITT:
            begin
                w    = 16;
                poly = {48'h0, mscrc_pkg::POLY_CCITT};
            end
            mscrc_pkg::VAR_ETH:
            begin
                w    = 32;
                poly = {32'h0, mscrc_pkg::RPOLY_ETH};
            end
            mscrc_pkg::VAR_P4:
            begin
                w    = 32;
                poly = {32'h0, mscrc_pkg::RPOLY_P4};
            end
            mscrc_pkg::VAR_ECMA:
            begin
                w    = 64;
                poly = mscrc_pkg::RPOLY_ECMA;
            end
            default:
            begin
                w    = 8;
                poly = {56'h0, mscrc_pkg::POLY_J1850};
            end
        endcase
        if (w <= 16)
        begin
            c = c ^ ({56'h0, data} << (w - 8));
            for (int i = 0; i < 8; i++)
            begin
                carry = c[w-1];
                c = (c << 1) & mask;
                if (carry)
                    c = c ^ poly;
            end
        end
        else
        begin
            c = c ^ {56'h0, data};
            for (int i = 0; i < 8; i++)
            begin
                carry = c[0];
                c = c >> 1;
                if (carry)
                    c = c ^ poly;
            end
        end
        return c & mask;
    endfunction

    function void take_item(logic [7:0] data, logic carries, logic closes);
        mscrc_pkg::variant_t         v;
        logic [mscrc_pkg::CRC_W-1:0] mask;
        logic [mscrc_pkg::CRC_W-1:0] cur;
        v = (variant_code > mscrc_pkg::VAR_ECMA) ? mscrc_pkg::VAR_J1850
                                                 : mscrc_pkg::variant_t'(variant_code);
        case (v)
            mscrc_pkg::VAR_CCITT:                    mask = 64'h0000_0000_0000_FFFF;
            mscrc_pkg::VAR_ETH, mscrc_pkg::VAR_P4:   mask = 64'h0000_0000_FFFF_FFFF;
            mscrc_pkg::VAR_ECMA:                     mask = mscrc_pkg::CRC_ALL_ONES;
            default:                                 mask = 64'h0000_0000_0000_00FF;
        endcase
        cur = running_crc & mask;
        if (carries)
        begin
            cur = fold_one_byte(cur, data, v, mask);
            running_crc = (running_crc & ~mask) | cur;
        end
        if (closes)
        begin
            pending_crcs.push_back((v == mscrc_pkg::VAR_CCITT) ? cur : (~cur & mask));
            running_crc = mscrc_pkg::CRC_ALL_ONES;
        end
    endfunction

    task report(string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        failures++;
    endtask

    task match_result(logic [mscrc_pkg::CRC_W-1:0] crc_value);
        logic [mscrc_pkg::CRC_W-1:0] want;
        if (pending_crcs.size() == 0)
        begin
            report($sformatf("unexpected crc transfer %h", crc_value));
        end
        else
        begin
            want = pending_crcs.pop_front();
            if (crc_value !== want)
                report($sformatf("crc_value %h, expected %h", crc_value, want));
        end
    endtask
endclass

module tb_multi_standard_crc_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mscrc_pkg::VARIANT_W-1:0] VAR_SPARE6 = 3'd6;
    localparam logic [mscrc_pkg::VARIANT_W-1:0] VAR_SPARE7 = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 85;

    logic clk;
    logic rst_n;

    mscrc_byte_if   byte_in ();
    mscrc_result_if crc_out ();
    mscrc_cfg_if    cfg ();

    multi_standard_crc_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .crc_out (crc_out),
        .cfg     (cfg)
    );

    crc_tracker book = new();

    int burst_left;
    int counted_items;
    bit hold_request;
    bit hold_served;
    int stall_mode;
    int mode_left;
    int tick;

    logic [mscrc_pkg::VARIANT_W-1:0] phase_codes[12] = '{
        mscrc_pkg::VAR_J1850, mscrc_pkg::VAR_H2F, mscrc_pkg::VAR_CCITT, mscrc_pkg::VAR_ETH,
        mscrc_pkg::VAR_P4, mscrc_pkg::VAR_ECMA, VAR_SPARE6, VAR_SPARE7,
        mscrc_pkg::VAR_ECMA, mscrc_pkg::VAR_J1850, mscrc_pkg::VAR_ETH, mscrc_pkg::VAR_CCITT};

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // one transfer on the byte channel, entered and left at a falling edge
    task automatic put_item(input logic [7:0] data, input logic carries, input logic closes);
        byte_in.valid          <= 1'b1;
        byte_in.data_byte      <= data;
        byte_in.carries_byte   <= carries;
        byte_in.end_of_message <= closes;
        do
            @(posedge clk);
        while (!byte_in.ready);
        book.take_item(data, carries, closes);
        if (carries || closes)
            counted_items++;
        @(negedge clk);
    endtask

    task automatic send_item(input logic [7:0] data, input logic carries, input logic closes);
        if (burst_left == 0)
        begin
            byte_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 16);
        end
        put_item(data, carries, closes);
        burst_left--;
    endtask

    task automatic write_variant(input logic [mscrc_pkg::VARIANT_W-1:0] code);
        byte_in.valid <= 1'b0;
        burst_left = 0;
        while (book.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg.valid       <= 1'b1;
        cfg.crc_variant <= code;
        do
            @(posedge clk);
        while (!cfg.ready);
        book.set_variant(code);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // well-formed message with random content, idle items mixed in
    task automatic send_message(input int max_len, input bit closed);
        int len;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        if (closed)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // result side: stall patterns, plus the long hold-off on request
    initial
    begin
        crc_out.ready = 1'b0;
        mode_left = 0;
        tick = 0;
        hold_served = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                crc_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 120);
                end
                mode_left--;
                tick++;
                case (stall_mode)
                    0:       crc_out.ready <= 1'b1;
                    1:       crc_out.ready <= 1'($urandom_range(0, 1));
                    2:       crc_out.ready <= (tick % 4 != 3);
                    default: crc_out.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && crc_out.valid && crc_out.ready)
            book.match_result(crc_out.crc_value);
    end

    initial
    begin
        logic [7:0] check_str[9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                                     8'h36, 8'h37, 8'h38, 8'h39};
        int phase_start;
        rst_n                  = 1'b0;
        byte_in.valid          = 1'b0;
        byte_in.data_byte      = 8'h00;
        byte_in.carries_byte   = 1'b0;
        byte_in.end_of_message = 1'b0;
        cfg.valid              = 1'b0;
        cfg.crc_variant        = mscrc_pkg::VAR_J1850;
        hold_request           = 1'b0;
        burst_left             = 0;
        counted_items          = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset variant: idle item, empty message, extreme bytes, check string
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        foreach (check_str[i])
            send_item(check_str[i], 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // variant change in the middle of an open message
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        write_variant(mscrc_pkg::VAR_ECMA);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);

        write_variant(mscrc_pkg::VAR_CCITT);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);

        foreach (phase_codes[p])
        begin
            write_variant(phase_codes[p]);
            phase_start = counted_items;
            if (p == 3)
                hold_request = 1'b1;
            while (counted_items - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                else
                    send_message((p == 3) ? 3 : 12, 1'b1);
            end
            // sometimes leave a message open across the variant change
            if (p != 11 && $urandom_range(0, 2) == 0)
                send_message(6, 1'b0);
        end

        byte_in.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (book.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
